// ----- src/uvc_pkg.sv -----
`default_nettype none
package uvc_pkg;

	// defaults for the top-level parameters
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int DEF_FRAC_BITS     = 16;

	// CORDIC datapath width, room for gain on a 33-bit vector
	localparam int CW = 36;

	// isqrt steps for a 64-bit radicand
	localparam int SQRT_STEPS = 32;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_CHECKER_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHECKER_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_RED      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_GREEN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_BLUE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_RED     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_GREEN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_BLUE    = 3'd7;

	// object kinds
	localparam logic [2:0] KIND_PLANE  = 3'd0;
	localparam logic [2:0] KIND_SPHERE = 3'd1;
	localparam logic [2:0] KIND_CONE   = 3'd2;
	localparam logic [2:0] KIND_CYL    = 3'd3;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_KIND = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	// beat sideband carried alongside the arithmetic
	typedef struct packed {
		logic              vld;
		logic [2:0]        kind;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} side_t;

	// atan(2^-k) in turns, Q0.32, truncated
	function automatic logic [31:0] atan_turn(input logic [4:0] k);
		logic [31:0] a;
		unique case (k)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051D;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2E;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2F9;
			5'd15: a = 32'h0000517C;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A2F;
			5'd19: a = 32'h00000517;
			5'd20: a = 32'h0000028B;
			5'd21: a = 32'h00000145;
			5'd22: a = 32'h000000A2;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000028;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000002;
			5'd29: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// ----- src/uvc_if.sv -----
`default_nettype none
// request channel: object kind and hit point
interface uvc_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;

	modport source(output valid, req_type, point_x, point_y, point_z, input ready);
	modport sink(input valid, req_type, point_x, point_y, point_z, output ready);
endinterface

// result channel: texture coordinates and checker colour
interface uvc_rsp_if;
	logic        valid;
	logic        ready;
	logic [16:0] tex_u;
	logic [16:0] tex_v;
	logic [15:0] out_red;
	logic [15:0] out_green;
	logic [15:0] out_blue;
	logic        chose_second;
	logic [1:0]  status;

	modport source(output valid, tex_u, tex_v, out_red, out_green, out_blue, chose_second,
		status, input ready);
	modport sink(input valid, tex_u, tex_v, out_red, out_green, out_blue, chose_second,
		status, output ready);
endinterface
`default_nettype wire

// ----- src/uvc_isqrt.sv -----
`default_nettype none
// pipelined digit-recurrence square root, one result bit per stage
module uvc_isqrt import uvc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] rad,
	output logic [31:0]      root
);

	logic [63:0] n_s [SQRT_STEPS];
	logic [63:0] r_s [SQRT_STEPS];

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
		logic [63:0] ni;
		logic [63:0] ri;
		logic [63:0] trial;

		if (j == 0) begin : g_first
			assign ni = rad;
			assign ri = '0;
		end else begin : g_next
			assign ni = n_s[j-1];
			assign ri = r_s[j-1];
		end

		assign trial = ri + BIT;

		// subtract the trial value when it fits
		always_ff @(posedge clk) begin
			if (en) begin
				if (ni >= trial) begin
					n_s[j] <= ni - trial;
					r_s[j] <= (ri >> 1) + BIT;
				end else begin
					n_s[j] <= ni;
					r_s[j] <= ri >> 1;
				end
			end
		end
	end

	assign root = r_s[SQRT_STEPS-1][31:0];

endmodule
`default_nettype wire

// ----- src/uvc_cordic.sv -----
`default_nettype none
// pipelined vectoring CORDIC: angle of (ab, ord) in turns, Q0.32
module uvc_cordic import uvc_pkg::*; #(
	parameter int STAGES = DEF_CORDIC_STAGES
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [CW-1:0] ord,
	input  wire logic signed [CW-1:0] ab,
	output logic [31:0]               ang
);

	logic signed [CW-1:0] ab_s  [STAGES+1];
	logic signed [CW-1:0] ord_s [STAGES+1];
	logic [31:0]          ang_s [STAGES+1];

	// half-turn pre-rotation for a negative abscissa
	always_ff @(posedge clk) begin
		if (en) begin
			if (ab < 0) begin
				ab_s[0]  <= -ab;
				ord_s[0] <= -ord;
				ang_s[0] <= 32'h8000_0000;
			end else begin
				ab_s[0]  <= ab;
				ord_s[0] <= ord;
				ang_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic [4:0] K = 5'(i % 32);
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;

		assign dx = ord_s[i] >>> K;
		assign dy = ab_s[i] >>> K;

		// drive the ordinate toward zero
		always_ff @(posedge clk) begin
			if (en) begin
				if (ord_s[i] >= 0) begin
					ab_s[i+1]  <= ab_s[i] + dx;
					ord_s[i+1] <= ord_s[i] - dy;
					ang_s[i+1] <= ang_s[i] + atan_turn(K);
				end else begin
					ab_s[i+1]  <= ab_s[i] - dx;
					ord_s[i+1] <= ord_s[i] + dy;
					ang_s[i+1] <= ang_s[i] - atan_turn(K);
				end
			end
		end
	end

	assign ang = ang_s[STAGES];

endmodule
`default_nettype wire

// ----- src/uv_checker_texture_map.sv -----
`default_nettype none
// UV checker texture map. Each request beat (object kind, Q16.16 hit point) yields one
// result beat with Q1.16 texture coordinates and a checker colour. The pipeline takes one
// beat per cycle while the result side is not stalled. The 32-step square root (sphere
// distance) is followed by the CORDIC angle pipelines. A stall on the result side
// freezes the whole pipeline. Configuration writes are expected only while no beat is
// in flight.
module uv_checker_texture_map import uvc_pkg::*; #(
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
	parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	uvc_req_if.sink                    req,
	uvc_rsp_if.source                  rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SQ_TAP = SQRT_STEPS + 1;
	localparam int CD_TAP = SQ_TAP + CORDIC_STAGES + 1;
	localparam int DLY    = CD_TAP + 1;
	localparam int FR_DN  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int FR_UP  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

	// configuration registers
	logic [19:0] width_q, height_q;
	logic [15:0] a_red_q, a_green_q, a_blue_q;
	logic [15:0] b_red_q, b_green_q, b_blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 20'd512;
			height_q  <= 20'd512;
			a_red_q   <= '0;
			a_green_q <= '0;
			a_blue_q  <= '0;
			b_red_q   <= '1;
			b_green_q <= '1;
			b_blue_q  <= '1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CHECKER_WIDTH:  width_q   <= cfg_data;
				REG_CHECKER_HEIGHT: height_q  <= cfg_data;
				REG_FIRST_RED:      a_red_q   <= cfg_data[15:0];
				REG_FIRST_GREEN:    a_green_q <= cfg_data[15:0];
				REG_FIRST_BLUE:     a_blue_q  <= cfg_data[15:0];
				REG_SECOND_RED:     b_red_q   <= cfg_data[15:0];
				REG_SECOND_GREEN:   b_green_q <= cfg_data[15:0];
				REG_SECOND_BLUE:    b_blue_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// pipeline advance: output register empty or being drained
	logic en;
	logic out_vld_q;

	assign en        = !out_vld_q || rsp.ready;
	assign req.ready = en;

	// input stage
	side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1.vld <= 1'b0;
		end else if (en) begin
			side_s1.vld  <= req.valid;
			side_s1.kind <= req.req_type;
			side_s1.x    <= req.point_x;
			side_s1.y    <= req.point_y;
			side_s1.z    <= req.point_z;
		end
	end

	// squares, then their sum
	logic signed [63:0] xx_c, zz_c;
	logic [63:0]        xx_s2, zz_s2, sum_s3;

	assign xx_c = side_s1.x * side_s1.x;
	assign zz_c = side_s1.z * side_s1.z;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2  <= xx_c;
			zz_s2  <= zz_c;
			sum_s3 <= xx_s2 + zz_s2;
		end
	end

	// sideband delay line matching the arithmetic latency
	side_t dly_s [DLY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DLY; i++) begin
				dly_s[i].vld <= 1'b0;
			end
		end else if (en) begin
			dly_s[0] <= side_s1;
			for (int i = 1; i < DLY; i++) begin
				dly_s[i] <= dly_s[i-1];
			end
		end
	end

	// distance in the xz plane
	logic [31:0] hyp;

	uvc_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s3),
		.root (hyp)
	);

	// azimuth from (z, x), polar angle from (y, h)
	logic [31:0] ang_u, ang_v;

	uvc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_u (
		.clk (clk),
		.en  (en),
		.ord (CW'(dly_s[SQ_TAP].x)),
		.ab  (CW'(dly_s[SQ_TAP].z)),
		.ang (ang_u)
	);

	uvc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_v (
		.clk (clk),
		.en  (en),
		.ord ($signed(CW'(hyp))),
		.ab  (CW'(dly_s[SQ_TAP].y)),
		.ang (ang_v)
	);

	function automatic logic [15:0] frac16(input logic [31:0] raw);
		logic [23:0] m;
		m = 24'(raw & ((32'd1 << FRAC_BITS) - 32'd1));
		return 16'((m << FR_UP) >> FR_DN);
	endfunction

	// coordinate selection per object kind
	side_t              sd;
	logic [31:0]        u_diff;
	logic [32:0]        u_wide;
	logic [16:0]        u_sph, v_sph;
	logic [31:0]        v_off;
	logic signed [33:0] ts, ts_cl;
	logic [33:0]        v_lin;
	logic [31:0]        cone_raw;
	logic [16:0]        u_c, v_c;
	logic [1:0]         st_c;

	assign sd       = dly_s[CD_TAP];
	// half turn minus the azimuth, modulo one turn, then rounded
	assign u_diff   = 32'h8000_0000 - ang_u;
	assign u_wide   = {1'b0, u_diff} + 33'h8000;
	assign u_sph    = u_wide[32:16];
	assign v_off    = ang_v - 32'h4000_0000;
	assign ts       = 34'($signed(v_off)) + 34'sh4000_0000;
	assign cone_raw = 32'(sd.y <<< 1) + (32'd1 << FRAC_BITS);

	always_comb begin
		if (ts < 0) begin
			ts_cl = '0;
		end else if (ts > 34'sh8000_0000) begin
			ts_cl = 34'sh8000_0000;
		end else begin
			ts_cl = ts;
		end
	end

	assign v_lin = 34'h1_0000_0000 - 34'(ts_cl <<< 1) + 34'h8000;
	assign v_sph = v_lin[32:16];

	always_comb begin
		u_c  = '0;
		v_c  = '0;
		st_c = ST_OK;
		case (sd.kind)
			KIND_PLANE: begin
				u_c = {1'b0, frac16(sd.x)};
				v_c = {1'b0, frac16(sd.z)};
			end
			KIND_SPHERE: begin
				if (sd.x == 0 && sd.y == 0 && sd.z == 0) begin
					st_c = ST_ZERO;
				end else begin
					u_c = u_sph;
					v_c = v_sph;
				end
			end
			KIND_CONE: begin
				u_c = u_sph;
				v_c = {1'b0, frac16(cone_raw)};
			end
			KIND_CYL: begin
				u_c = u_sph;
				v_c = {1'b0, frac16(sd.y)};
			end
			default: st_c = ST_KIND;
		endcase
	end

	logic        vld_s5;
	logic [16:0] u_s5, v_s5;
	logic [1:0]  st_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= sd.vld;
			u_s5   <= u_c;
			v_s5   <= v_c;
			st_s5  <= st_c;
		end
	end

	// checker parity and colour pick
	logic [36:0] pu, pv;
	logic        odd;

	assign pu  = 37'(u_s5) * 37'(width_q);
	assign pv  = 37'(v_s5) * 37'(height_q);
	assign odd = (st_s5 == ST_OK) && (pu[24] ^ pv[24]);

	logic [16:0] u_q, v_q;
	logic [15:0] r_q, g_q, b_q;
	logic        odd_q;
	logic [1:0]  st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s5;
			u_q       <= u_s5;
			v_q       <= v_s5;
			st_q      <= st_s5;
			odd_q     <= odd;
			if (st_s5 == ST_KIND) begin
				r_q <= '0;
				g_q <= '0;
				b_q <= '0;
			end else if (odd) begin
				r_q <= b_red_q;
				g_q <= b_green_q;
				b_q <= b_blue_q;
			end else begin
				r_q <= a_red_q;
				g_q <= a_green_q;
				b_q <= a_blue_q;
			end
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.tex_u        = u_q;
	assign rsp.tex_v        = v_q;
	assign rsp.out_red      = r_q;
	assign rsp.out_green    = g_q;
	assign rsp.out_blue     = b_q;
	assign rsp.chose_second = odd_q;
	assign rsp.status       = st_q;

	// unknown kind carries no colour
	a_kind_black: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_KIND |->
			rsp.out_red == 0 && rsp.out_green == 0 && rsp.out_blue == 0 && !rsp.chose_second)
		else $error("unknown kind produced a colour");

	// coordinates never exceed 1.0
	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.tex_u <= 17'h10000 && rsp.tex_v <= 17'h10000)
		else $error("texture coordinate out of range");

	// a stalled output freezes the pipeline entry
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("input taken while output stalled");

endmodule
`default_nettype wire
